### rtl/tcrb_pkg.sv
// ----------------------------------------------------------------------------
// tcrb_pkg
// Shared types and constants for the tty character ring buffer: beat
// layouts, op codes, status codes and storage geometry.
// ----------------------------------------------------------------------------
package tcrb_pkg;

    // Storage geometry
    localparam int DEPTH = 256;
    localparam int POS_W = $clog2(DEPTH);      // position / address width
    localparam int CNT_W = $clog2(DEPTH + 1);  // counts up to DEPTH

    // Op codes
    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_GET   = 3'd1;
    localparam logic [2:0] OP_FLUSH = 3'd2;
    localparam logic [2:0] OP_SCAN  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Input beat
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_in;
        logic [8:0] drop_count;
        logic [7:0] stop_mask;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [7:0] data_out;
        logic [1:0] status;
        logic [8:0] run_count;
        logic [7:0] fill_level;
    } t_out_beat;

endpackage

### rtl/tcrb_store.sv
// ----------------------------------------------------------------------------
// tcrb_store
// Byte storage of the ring buffer: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcrb_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [tcrb_pkg::POS_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic [tcrb_pkg::POS_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import tcrb_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tty_character_ring_buffer.sv
// ----------------------------------------------------------------------------
// tty_character_ring_buffer
// Byte ring buffer with one slot kept empty. Put, get, flush, scan and
// clear ops; in-use size set by a configuration register.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | beat
//  ----------+---------------------------+-----------------------------------
//  input     | i_in_valid / o_in_ready   | i_in_data  (t_in_beat)
//  output    | o_out_valid / i_out_ready | o_out_data (t_out_beat)
//  config    | i_cfg_we (no wait)        | i_cfg_data (buffer_size, 9 bits)
//
//  One op at a time: a sequencer runs each accepted beat. Put, flush and
//  clear finish in the execute state; get adds a state for the registered
//  storage read. Scan walks one entry at a time through the storage read
//  port, with a fetch state and a check state per entry, and ends at the
//  limit or when a stop byte ends it, run up to DEPTH-1.
//  The result register lets the next beat be taken while a result waits;
//  a finished result that finds the register busy parks until it drains.
//  Reset (synchronous, active low) empties the buffer, size = DEPTH.
//  A config write saturates the size to 2..DEPTH and empties the buffer.
// ----------------------------------------------------------------------------
module tty_character_ring_buffer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcrb_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tcrb_pkg::t_out_beat  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [8:0]           i_cfg_data
);
    import tcrb_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_GETD = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_SCHK = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_size, n_size;
    logic [POS_W-1:0] r_rd_pos, n_rd_pos;
    logic [POS_W-1:0] r_wr_pos, n_wr_pos;
    logic [POS_W-1:0] r_occ, n_occ;
    t_in_beat         r_item, n_item;
    t_out_beat        r_res, n_res;
    t_out_beat        r_out_data, n_out_data;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_scan_p, n_scan_p;
    logic [CNT_W-1:0] r_lim, n_lim;

    logic             mem_we;
    logic [POS_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;

    logic             fin;
    t_out_beat        res;
    logic             out_free;
    logic [CNT_W-1:0] wr_inc, rd_inc, flush_n, flush_p, cfg_sat;
    logic [POS_W-1:0] wr_next, rd_next;

    tcrb_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_pos),
        .i_wdata (r_item.data_in),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Wrapped successors of both positions
    always_comb begin
        wr_inc  = {1'b0, r_wr_pos} + CNT_W'(1);
        rd_inc  = {1'b0, r_rd_pos} + CNT_W'(1);
        wr_next = (wr_inc >= r_size) ? '0 : wr_inc[POS_W-1:0];
        rd_next = (rd_inc >= r_size) ? '0 : rd_inc[POS_W-1:0];
    end

    // Flush amount and new read position
    always_comb begin
        flush_n = (r_item.drop_count < {1'b0, r_occ}) ? r_item.drop_count
                                                      : {1'b0, r_occ};
        flush_p = {1'b0, r_rd_pos} + flush_n;
        if (flush_p >= r_size) begin
            flush_p = flush_p - r_size;
        end
    end

    // Saturated size from a config write
    always_comb begin
        cfg_sat = i_cfg_data;
        if (cfg_sat < CNT_W'(2)) begin
            cfg_sat = CNT_W'(2);
        end else if (cfg_sat > CNT_W'(DEPTH)) begin
            cfg_sat = CNT_W'(DEPTH);
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_rd_pos    = r_rd_pos;
        n_wr_pos    = r_wr_pos;
        n_occ       = r_occ;
        n_item      = r_item;
        n_res       = r_res;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;
        n_scan_p    = r_scan_p;
        n_lim       = r_lim;
        mem_we      = 1'b0;
        mem_raddr   = r_rd_pos;
        fin         = 1'b0;
        res         = '0;

        // result register drains
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_item.op)
                    OP_PUT: begin
                        fin = 1'b1;
                        if (wr_next == r_rd_pos) begin
                            res.status = ST_FULL;
                        end else begin
                            mem_we   = 1'b1;
                            n_wr_pos = wr_next;
                            n_occ    = r_occ + POS_W'(1);
                        end
                    end
                    OP_GET: begin
                        if (r_rd_pos == r_wr_pos) begin
                            fin        = 1'b1;
                            res.status = ST_EMPTY;
                        end else begin
                            n_state = S_GETD;
                        end
                    end
                    OP_FLUSH: begin
                        fin           = 1'b1;
                        n_rd_pos      = flush_p[POS_W-1:0];
                        n_occ         = r_occ - flush_n[POS_W-1:0];
                        res.run_count = flush_n;
                    end
                    OP_SCAN: begin
                        n_scan_p = {1'b0, r_rd_pos};
                        n_lim    = (r_wr_pos < r_rd_pos) ? r_size : {1'b0, r_wr_pos};
                        n_state  = S_SCAN;
                    end
                    OP_CLEAR: begin
                        fin      = 1'b1;
                        n_rd_pos = '0;
                        n_wr_pos = '0;
                        n_occ    = '0;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_GETD: begin
                fin          = 1'b1;
                res.data_out = mem_rdata;
                n_rd_pos     = rd_next;
                n_occ        = r_occ - POS_W'(1);
            end
            S_SCAN: begin
                // stop at the limit, else fetch the next entry
                mem_raddr = r_scan_p[POS_W-1:0];
                if (r_scan_p >= r_lim) begin
                    fin           = 1'b1;
                    res.run_count = r_scan_p - {1'b0, r_rd_pos};
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if ((r_item.stop_mask & mem_rdata) != 8'd0) begin
                    fin           = 1'b1;
                    res.run_count = r_scan_p - {1'b0, r_rd_pos};
                end else begin
                    n_scan_p = r_scan_p + CNT_W'(1);
                    n_state  = S_SCAN;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_data  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.fill_level = n_occ;

        // finished op: hand to the result register or park it
        if (fin) begin
            if (out_free) begin
                n_out_data  = res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_OUT;
            end
        end

        // config write empties the buffer
        if (i_cfg_we) begin
            n_size   = cfg_sat;
            n_rd_pos = '0;
            n_wr_pos = '0;
            n_occ    = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= CNT_W'(DEPTH);
            r_rd_pos    <= '0;
            r_wr_pos    <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_rd_pos    <= n_rd_pos;
            r_wr_pos    <= n_wr_pos;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_scan_p   <= n_scan_p;
        r_lim      <= n_lim;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Occupancy matches the distance between the positions
    a_occ_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == ((r_wr_pos >= r_rd_pos)
                  ? (r_wr_pos - r_rd_pos)
                  : POS_W'({1'b0, r_wr_pos} + r_size - {1'b0, r_rd_pos})))
        else $error("occupancy out of step with positions");

    // Positions stay inside the in-use slots, size stays in range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rd_pos} < r_size) && ({1'b0, r_wr_pos} < r_size)
        && (r_size >= CNT_W'(2)) && (r_size <= CNT_W'(DEPTH)))
        else $error("position or size out of range");

    // One beat at a time: ready drops right after an accept
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

    // A rejected put reports a full buffer
    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FULL) && !i_cfg_we
         && !$past(i_cfg_we))
        |-> ({1'b0, o_out_data.fill_level} == r_size - CNT_W'(1)))
        else $error("full status below capacity");

endmodule

### dv/tb_tty_character_ring_buffer.sv
// ----------------------------------------------------------------------------
// tb_tty_character_ring_buffer
// Self-checking bench for the byte ring buffer. A predictor in the bench
// tracks storage, positions and fill level, and computes each result beat
// when an input beat is accepted. A checker process compares every output
// beat with the oldest prediction. Directed ops come first, then biased
// random traffic over several buffer sizes, a long receiver hold-off,
// and three idle mixes on the two channels.
// ----------------------------------------------------------------------------
module tb_tty_character_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcrb_pkg::*;

    // Op codes the block leaves unused
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // DUT ports
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       in_valid   = 1'b0;
    logic       o_in_ready;
    t_in_beat   in_data    = '0;
    logic       o_out_valid;
    logic       out_ready  = 1'b0;
    t_out_beat  o_out_data;
    logic       cfg_we     = 1'b0;
    logic [8:0] cfg_data   = '0;

    // Predictor state
    logic [7:0] ring_mem [DEPTH];
    int         rd_pos    = 0;
    int         wr_pos    = 0;
    int         held      = 0;
    int         ring_size = DEPTH;

    // Expected result beats, oldest first
    t_out_beat  pending_results [$];
    t_out_beat  exp_beat;
    int         mismatch_count = 0;

    // Idle mix and receiver hold-off
    int         send_idle_pct = 13;
    int         recv_idle_pct = 60;
    logic       out_hold      = 1'b0;
    bit         filling       = 1'b1;

    tty_character_ring_buffer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #60000000;
        $display("[tty_character_ring_buffer] ERROR");
        $finish;
    end

    function automatic int ring_next(int p);
        return (p + 1 >= ring_size) ? 0 : p + 1;
    endfunction

    // Apply one op to the predicted state; return the result it yields
    function automatic t_out_beat ring_apply(t_in_beat b);
        t_out_beat r;
        int        p;
        int        lim;
        int        n;
        r = '0;
        case (b.op)
            OP_PUT: begin
                p = ring_next(wr_pos);
                if (p == rd_pos) begin
                    r.status = ST_FULL;
                end else begin
                    ring_mem[POS_W'(wr_pos)] = b.data_in;
                    wr_pos = p;
                    held++;
                end
            end
            OP_GET: begin
                if (rd_pos == wr_pos) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = ring_mem[POS_W'(rd_pos)];
                    rd_pos = ring_next(rd_pos);
                    held--;
                end
            end
            OP_FLUSH: begin
                n = (int'(b.drop_count) < held) ? int'(b.drop_count) : held;
                p = rd_pos + n;
                if (p >= ring_size) p -= ring_size;
                rd_pos = p;
                held -= n;
                r.run_count = 9'(n);
            end
            OP_SCAN: begin
                // contiguous run up to buffer end or write position
                lim = (wr_pos < rd_pos) ? ring_size : wr_pos;
                p = rd_pos;
                while (p < lim &&
                       !(b.stop_mask != 0 && (ring_mem[POS_W'(p)] & b.stop_mask) != 0))
                    p++;
                r.run_count = 9'(p - rd_pos);
            end
            OP_CLEAR: begin
                rd_pos = 0;
                wr_pos = 0;
                held = 0;
            end
            default: ;
        endcase
        r.fill_level = held[7:0];
        return r;
    endfunction

    function automatic t_in_beat beat_of(logic [2:0] op, logic [7:0] data,
                                         logic [8:0] drop, logic [7:0] mask);
        t_in_beat b;
        b.op = op;
        b.data_in = data;
        b.drop_count = drop;
        b.stop_mask = mask;
        return b;
    endfunction

    // Biased random beat: fill phases mostly put, drain phases mostly take
    function automatic t_in_beat random_beat();
        t_in_beat b;
        int       r;
        b = t_in_beat'($bits(t_in_beat)'($urandom));
        r = $urandom_range(99);
        if (r < 2)                   b.op = OP_CLEAR;
        else if (r < 4)              b.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else if (r < (filling ? 84 : 14)) b.op = OP_PUT;
        else if (r < (filling ? 90 : 60)) b.op = OP_GET;
        else if (r < (filling ? 94 : 76)) b.op = OP_FLUSH;
        else                         b.op = OP_SCAN;
        // mostly short flushes, some over the whole field
        if ($urandom_range(4) != 0) b.drop_count = 9'($urandom_range(0, 12));
        case ($urandom_range(3))
            0: b.stop_mask = 8'h00;
            1, 2: b.stop_mask = 8'h01 << $urandom_range(7);
            default: ;
        endcase
        return b;
    endfunction

    // Offer one beat, wait for the handshake, record the prediction
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 50) gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_results.push_back(ring_apply(b));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Size register write, only with the block idle
    task automatic set_ring_size(logic [8:0] v);
        int sz;
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sz = int'(v);
        if (sz < 2) sz = 2;
        if (sz > DEPTH) sz = DEPTH;
        ring_size = sz;
        rd_pos = 0;
        wr_pos = 0;
        held = 0;
        @(posedge i_clk);
    endtask

    task automatic test_empty_ops();
        send_beat(beat_of(OP_GET,   8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_SCAN,  8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_FLUSH, 8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_FLUSH, 8'h00, 9'd256, 8'h00));
        send_beat(beat_of(OP_UNUSED_LO, 8'h00, 9'd0, 8'h00));
        send_beat(beat_of(OP_UNUSED_HI, 8'hFF, 9'h1FF, 8'hFF));
    endtask

    task automatic test_basic_ops();
        send_beat(beat_of(OP_PUT,   8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_PUT,   8'hFF, 9'd0,   8'h00));
        send_beat(beat_of(OP_PUT,   8'h80, 9'd0,   8'h00));
        send_beat(beat_of(OP_PUT,   8'h01, 9'd0,   8'h00));
        send_beat(beat_of(OP_SCAN,  8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_SCAN,  8'h00, 9'd0,   8'h80));
        send_beat(beat_of(OP_SCAN,  8'h00, 9'd0,   8'h01));
        send_beat(beat_of(OP_GET,   8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_FLUSH, 8'h00, 9'd1,   8'h00));
        send_beat(beat_of(OP_FLUSH, 8'h00, 9'h1FF, 8'h00));
        send_beat(beat_of(OP_PUT,   8'h5A, 9'd0,   8'h00));
        send_beat(beat_of(OP_CLEAR, 8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_GET,   8'h00, 9'd0,   8'h00));
    endtask

    // Smallest buffer goes full at once; size 3 wraps the write position
    task automatic test_full_and_wrap();
        set_ring_size(9'd0);
        send_beat(beat_of(OP_PUT,   8'h11, 9'd0,   8'h00));
        send_beat(beat_of(OP_PUT,   8'h22, 9'd0,   8'h00));
        send_beat(beat_of(OP_GET,   8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_GET,   8'h00, 9'd0,   8'h00));
        set_ring_size(9'd3);
        send_beat(beat_of(OP_PUT,   8'hA1, 9'd0,   8'h00));
        send_beat(beat_of(OP_PUT,   8'hB2, 9'd0,   8'h00));
        send_beat(beat_of(OP_GET,   8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_PUT,   8'hC3, 9'd0,   8'h00));
        send_beat(beat_of(OP_SCAN,  8'h00, 9'd0,   8'h00));
        send_beat(beat_of(OP_PUT,   8'hD4, 9'd0,   8'h00));
        send_beat(beat_of(OP_FLUSH, 8'h00, 9'd300, 8'h00));
    endtask

    task automatic test_random(int n_beats);
        filling = 1'b1;
        repeat (n_beats) begin
            if (held >= ring_size - 1) filling = 1'b0;
            else if (held == 0) filling = 1'b1;
            else if ($urandom_range(199) == 0) filling = !filling;
            send_beat(random_beat());
        end
    endtask

    // Receiver holds off long enough that the input side must stall
    task automatic test_backpressure();
        set_ring_size(9'd16);
        fork
            begin
                out_hold <= 1'b1;
                repeat (400) @(posedge i_clk);
                out_hold <= 1'b0;
            end
            test_random(40);
        join
    endtask

    // Output side: check each accepted beat, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: data=%02h st=%0d run=%0d fill=%0d",
                             o_out_data.data_out, o_out_data.status,
                             o_out_data.run_count, o_out_data.fill_level);
            end else begin
                exp_beat = pending_results.pop_front();
                if (o_out_data.data_out   !== exp_beat.data_out  ||
                    o_out_data.status     !== exp_beat.status    ||
                    o_out_data.run_count  !== exp_beat.run_count ||
                    o_out_data.fill_level !== exp_beat.fill_level) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp data=%02h st=%0d run=%0d fill=%0d, ",
                                  "got data=%02h st=%0d run=%0d fill=%0d"},
                                 exp_beat.data_out, exp_beat.status,
                                 exp_beat.run_count, exp_beat.fill_level,
                                 o_out_data.data_out, o_out_data.status,
                                 o_out_data.run_count, o_out_data.fill_level);
                end
            end
        end
        if (out_hold) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        test_empty_ops();
        test_basic_ops();
        test_full_and_wrap();
        set_ring_size(9'h1FF);
        test_random(350);

        // the other way round
        wait_drained();
        send_idle_pct = 60;
        recv_idle_pct <= 13;
        set_ring_size(9'd257);
        test_random(350);
        set_ring_size(9'd1);
        test_random(150);
        set_ring_size(9'd5);
        test_random(200);

        // no idling
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_backpressure();
        set_ring_size(9'($urandom_range(4, 64)));
        test_random(300);
        set_ring_size(9'd255);
        test_random(300);
        set_ring_size(9'd256);
        test_random(100);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("[tty_character_ring_buffer] OK");
        end else begin
            $display("[tty_character_ring_buffer] ERROR");
        end
        $finish;
    end

endmodule
